/* src/hcft_pkg.sv */
// Shared types and constants for the haptic command frame and timer block.
// No dependencies; every other file of the block refers to it by scoped names.
package hcft_pkg;

    localparam int FRAME_LEN = 7;

    localparam logic [7:0] HEAD0 = 8'h55;
    localparam logic [7:0] HEAD1 = 8'hAA;
    localparam logic [3:0] LIMIT_RESET = 4'd5;

    typedef enum logic [2:0] {
        OP_BYTE   = 3'd0,
        OP_END    = 3'd1,
        OP_TICK   = 3'd2,
        OP_RELOAD = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_NONE   = 3'd0,
        ST_OK     = 3'd1,
        ST_HEADER = 3'd2,
        ST_SUM    = 3'd3,
        ST_RANGE  = 3'd4,
        ST_SHORT  = 3'd5
    } status_t;

    // One classified request as it waits in the queue.
    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic [2:0]  channel;
    } cmd_t;

    // Handshake between queue and its neighbors.
    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

    // One result as held in the output register.
    typedef struct packed {
        status_t     status;
        logic [7:0]  last_channel;
        logic [7:0]  wave;
        logic [15:0] duration;
        logic [15:0] count;
        logic [15:0] stamp;
    } result_t;

endpackage

/* src/hcft_front.sv */
// Front end: accepts input requests and classifies the opcode.
// Depends on hcft_pkg; feeds hcft_queue.
module hcft_front (
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [2:0]             opcode,
    input  logic [7:0]             data_byte,
    input  logic [2:0]             channel,
    input  hcft_pkg::q_status_t    q_status,
    output logic                   push,
    output hcft_pkg::cmd_t         push_cmd
);

    hcft_pkg::op_t op_dec;

    // Map unused opcodes onto a plain read.
    always_comb
    begin
        case (opcode)
            3'(hcft_pkg::OP_BYTE):   op_dec = hcft_pkg::OP_BYTE;
            3'(hcft_pkg::OP_END):    op_dec = hcft_pkg::OP_END;
            3'(hcft_pkg::OP_TICK):   op_dec = hcft_pkg::OP_TICK;
            3'(hcft_pkg::OP_RELOAD): op_dec = hcft_pkg::OP_RELOAD;
            default:                 op_dec = hcft_pkg::OP_READ;
        endcase
    end

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

    always_comb
    begin
        push_cmd.op      = op_dec;
        push_cmd.data    = (op_dec == hcft_pkg::OP_BYTE) ? data_byte : 8'h00;
        push_cmd.channel = channel;
    end

endmodule

/* src/hcft_queue.sv */
// Two-entry request queue between the front end and the execution back end.
// Depends on hcft_pkg.
module hcft_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  hcft_pkg::cmd_t         push_cmd,
    input  logic                   pop,
    output hcft_pkg::q_status_t    q_status,
    output hcft_pkg::cmd_t         pop_cmd
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    hcft_pkg::cmd_t     entry_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      rd_ptr_reg;
    logic [PW:0]        count_reg;
    logic [PW:0]        count_next;

    assign q_status.valid = (count_reg != '0);
    assign q_status.full  = (count_reg == (PW+1)'(DEPTH));
    assign pop_cmd        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* src/hcft_back.sv */
// Back end: frame assembly and judging, channel tables, countdowns, timestamp,
// configuration register and the output register. Depends on hcft_pkg.
module hcft_back #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  hcft_pkg::cmd_t         cmd,
    output logic                   pop,
    input  logic                   cfg_we,
    input  logic [3:0]             cfg_limit,
    input  logic                   out_stall,
    output logic                   out_valid,
    output hcft_pkg::result_t      result
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [7:0] NCH8 = 8'(NUM_CHANNELS);

    logic [3:0]          limit_reg;
    logic [2:0]          pos_reg, pos_next;
    logic [7:0]          frame_reg [hcft_pkg::FRAME_LEN];
    logic [7:0]          frame_next [hcft_pkg::FRAME_LEN];
    logic [7:0]          rec_reg, rec_next;
    logic [7:0]          wave_reg [NUM_CHANNELS];
    logic [7:0]          wave_next [NUM_CHANNELS];
    logic [15:0]         dur_reg [NUM_CHANNELS];
    logic [15:0]         dur_next [NUM_CHANNELS];
    logic [15:0]         cnt_reg [NUM_CHANNELS];
    logic [15:0]         cnt_next [NUM_CHANNELS];
    logic [15:0]         stamp_reg, stamp_next;
    hcft_pkg::status_t   status;
    logic                out_valid_reg;
    hcft_pkg::result_t   result_reg, result_next;

    assign pop       = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        logic [7:0]      sum;
        logic [7:0]      fch;
        logic [CH_W-1:0] fidx;
        logic [CH_W-1:0] ridx;
        logic            ch_ok;

        pos_next   = pos_reg;
        frame_next = frame_reg;
        rec_next   = rec_reg;
        wave_next  = wave_reg;
        dur_next   = dur_reg;
        cnt_next   = cnt_reg;
        stamp_next = stamp_reg;
        status     = hcft_pkg::ST_NONE;

        sum   = frame_reg[2] + frame_reg[3] + frame_reg[4] + frame_reg[5];
        fch   = frame_reg[2];
        fidx  = CH_W'(fch);
        ridx  = CH_W'(cmd.channel);
        ch_ok = (8'(cmd.channel) < NCH8);

        case (cmd.op)
            hcft_pkg::OP_BYTE:
            begin
                // Drop bytes past the end of a frame.
                if (pos_reg < 3'(hcft_pkg::FRAME_LEN))
                begin
                    frame_next[pos_reg] = cmd.data;
                    pos_next            = pos_reg + 1'b1;
                end
            end
            hcft_pkg::OP_END:
            begin
                pos_next = '0;
                if (pos_reg < 3'(hcft_pkg::FRAME_LEN))
                begin
                    status = hcft_pkg::ST_SHORT;
                end
                else if (frame_reg[0] != hcft_pkg::HEAD0 ||
                         frame_reg[1] != hcft_pkg::HEAD1)
                begin
                    status = hcft_pkg::ST_HEADER;
                end
                else if (sum != frame_reg[6])
                begin
                    status = hcft_pkg::ST_SUM;
                end
                else
                begin
                    rec_next = fch;
                    if (fch >= {4'b0, limit_reg} || fch >= NCH8)
                    begin
                        status = hcft_pkg::ST_RANGE;
                    end
                    else
                    begin
                        status          = hcft_pkg::ST_OK;
                        wave_next[fidx] = frame_reg[3];
                        dur_next[fidx]  = {frame_reg[4], frame_reg[5]};
                        cnt_next[fidx]  = '0;
                    end
                end
            end
            hcft_pkg::OP_TICK:
            begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    if (cnt_reg[i] != '0)
                    begin
                        cnt_next[i] = cnt_reg[i] - 1'b1;
                    end
                end
                stamp_next = stamp_reg + 1'b1;
            end
            hcft_pkg::OP_RELOAD:
            begin
                if (ch_ok)
                begin
                    cnt_next[ridx] = dur_reg[ridx];
                end
            end
            default:
            begin
            end
        endcase

        // Report the state after this request has taken effect.
        result_next.status       = status;
        result_next.last_channel = rec_next;
        result_next.stamp        = stamp_next;
        if (ch_ok)
        begin
            result_next.wave     = wave_next[ridx];
            result_next.duration = dur_next[ridx];
            result_next.count    = cnt_next[ridx];
        end
        else
        begin
            result_next.wave     = '0;
            result_next.duration = '0;
            result_next.count    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= hcft_pkg::LIMIT_RESET;
            pos_reg       <= '0;
            rec_reg       <= '0;
            stamp_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < hcft_pkg::FRAME_LEN; i++)
            begin
                frame_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                wave_reg[i] <= '0;
                dur_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_limit;
            end
            if (pop)
            begin
                pos_reg   <= pos_next;
                frame_reg <= frame_next;
                rec_reg   <= rec_next;
                wave_reg  <= wave_next;
                dur_reg   <= dur_next;
                cnt_reg   <= cnt_next;
                stamp_reg <= stamp_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

endmodule

/* src/haptic_command_frame_and_timers.sv */
// Top level of the haptic command frame receiver with channel countdown timers.
// Depends on hcft_pkg, hcft_front, hcft_queue and hcft_back.
//
// Requests enter on a valid/stall channel, one per cycle while in_stall is low: each
// request is one serial byte, a frame end, a millisecond tick, a counter
// reload or a read, and every request gives exactly one result on the output
// valid/stall channel, in order. A frame is 0x55, 0xAA, channel, waveform,
// duration high, duration low and an 8-bit sum of the four middle bytes; a
// frame end judges the bytes gathered since the previous frame end and
// reports accepted, bad header, bad checksum, channel out of range or short
// frame. The front end classifies each request and pushes it into a two-entry
// queue; the back end pops one request per cycle unless the output register is
// stalled, updates the frame buffer, channel tables, all countdowns in parallel
// and the timestamp in that same cycle, and loads the output register. A request
// is written into the queue, then popped into the output register, which drives
// out_valid; the sustained rate is one request per cycle while out_stall is low.
// in_stall rises only when the queue holds two requests, i.e. when the
// output side has been stalled. The valid_channel_limit register (reset 5)
// is written through cfg_valid/cfg_ready, which is always ready; write it
// only while no request is in flight.
module haptic_command_frame_and_timers #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic         clk,
    input  logic         rst_n,

    // Request channel
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [2:0]   opcode,
    input  logic [7:0]   data_byte,
    input  logic [2:0]   channel,

    // Result channel
    output logic         out_valid,
    input  logic         out_stall,
    output logic [2:0]   frame_status,
    output logic [7:0]   last_channel,
    output logic [7:0]   wave_number,
    output logic [15:0]  channel_duration,
    output logic [15:0]  channel_count,
    output logic [15:0]  time_stamp,

    // Configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   valid_channel_limit
);

    hcft_pkg::q_status_t q_status;
    hcft_pkg::cmd_t      push_cmd;
    hcft_pkg::cmd_t      pop_cmd;
    hcft_pkg::result_t   result;
    logic                push;
    logic                pop;

    // The limit register never blocks a write.
    assign cfg_ready = 1'b1;

    hcft_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .data_byte (data_byte),
        .channel   (channel),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    hcft_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .q_status (q_status),
        .pop_cmd  (pop_cmd)
    );

    hcft_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_status.valid),
        .cmd       (pop_cmd),
        .pop       (pop),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_limit (valid_channel_limit),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .result    (result)
    );

    // Unpack the output register onto the result ports.
    assign frame_status     = 3'(result.status);
    assign last_channel     = result.last_channel;
    assign wave_number      = result.wave;
    assign channel_duration = result.duration;
    assign channel_count    = result.count;
    assign time_stamp       = result.stamp;

endmodule

/* src/hcft_checker.sv */
// Port-level checker for haptic_command_frame_and_timers, bound to the top level.
// Depends on hcft_pkg.
module hcft_checker #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_stall,
    input  logic         out_valid,
    input  logic         out_stall,
    input  logic [2:0]   frame_status,
    input  logic [7:0]   last_channel,
    input  logic [15:0]  time_stamp,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [3:0]   valid_channel_limit
);

    logic        in_fire;
    logic        out_fire;
    logic [2:0]  pending_reg;
    logic [15:0] last_ts_reg;
    logic        seen_reg;
    logic [3:0]  limit_reg;

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            last_ts_reg <= '0;
            seen_reg    <= 1'b0;
            limit_reg   <= hcft_pkg::LIMIT_RESET;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(in_fire) - 3'(out_fire);
            if (out_fire)
            begin
                last_ts_reg <= time_stamp;
                seen_reg    <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= valid_channel_limit;
            end
        end
    end

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(time_stamp) && $stable(frame_status))
        else $error("stalled result changed");

    // No result without a request still owed one.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result without outstanding request");

    // Consecutive results differ by at most one tick.
    a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && seen_reg |->
            time_stamp == last_ts_reg || time_stamp == last_ts_reg + 16'd1)
        else $error("timestamp jumped between results");

    // An accepted frame names a channel below the limit and the table size.
    a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_status == 3'(hcft_pkg::ST_OK) |->
            last_channel < {4'b0, limit_reg} && last_channel < 8'(NUM_CHANNELS))
        else $error("accepted frame with channel out of range");

endmodule

bind haptic_command_frame_and_timers hcft_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_hcft_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .frame_status        (frame_status),
    .last_channel        (last_channel),
    .time_stamp          (time_stamp),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .valid_channel_limit (valid_channel_limit)
);

/* test/haptic_command_frame_and_timers_tb.sv */
// Self-checking testbench for haptic_command_frame_and_timers: directed table and
// four randomized phases, each result checked against an in-bench model.
// Depends on hcft_pkg and the RTL of the block; no files, no arguments.
module haptic_command_frame_and_timers_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH = 8;
    localparam int RANDOM_PER_PHASE = 406;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTED = 30;
    localparam int TAIL_CYCLES = 8;

    // Opcodes the block does not define; they behave like a read.
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    // One request as driven on the input channel. A typed-in status rides along
    // with the payload so the checker picks it up at the same edge.
    typedef struct packed {
        logic [2:0]        op;
        logic [7:0]        data;
        logic [2:0]        ch;
        logic              pinned;
        hcft_pkg::status_t pin_st;
    } req_t;

    // Directed part: one frame that passes (plus an eighth byte to drop), reload
    // and tick on it, a tick on an empty counter, an empty frame end, a frame
    // naming channel 0xFF, and two unused opcodes. Frame ends carry their status.
    localparam int N_DIRECTED = 24;
    localparam req_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{hcft_pkg::OP_READ,   8'h00, 3'd0, 1'b1, hcft_pkg::ST_NONE},
        '{hcft_pkg::OP_BYTE,   8'h55, 3'd1, 1'b0, hcft_pkg::ST_NONE},
        '{hcft_pkg::OP_BYTE,   8'hAA, 3'd2, 1'b0, hcft_pkg::ST_NONE},
        '{hcft_pkg::OP_BYTE,   8'h02, 3'd3, 1'b0, hcft_pkg::ST_NONE},
        '{hcft_pkg::OP_BYTE,   8'h7F, 3'd4, 1'b0, hcft_pkg::ST_NONE},
        '{hcft_pkg::OP_BYTE,   8'hFF, 3'd5, 1'b0, hcft_pkg::ST_NONE},
        '{hcft_pkg::OP_BYTE,   8'hFF, 3'd6, 1'b0, hcft_pkg::ST_NONE},
        '{hcft_pkg::OP_BYTE,   8'h7F, 3'd7, 1'b0, hcft_pkg::ST_NONE},
        '{hcft_pkg::OP_BYTE,   8'h00, 3'd0, 1'b0, hcft_pkg::ST_NONE},
        '{hcft_pkg::OP_END,    8'h00, 3'd2, 1'b1, hcft_pkg::ST_OK},
        '{hcft_pkg::OP_RELOAD, 8'h00, 3'd2, 1'b0, hcft_pkg::ST_NONE},
        '{hcft_pkg::OP_TICK,   8'hFF, 3'd2, 1'b0, hcft_pkg::ST_NONE},
        '{hcft_pkg::OP_TICK,   8'h00, 3'd0, 1'b0, hcft_pkg::ST_NONE},
        '{hcft_pkg::OP_END,    8'h00, 3'd0, 1'b1, hcft_pkg::ST_SHORT},
        '{hcft_pkg::OP_BYTE,   8'h55, 3'd0, 1'b0, hcft_pkg::ST_NONE},
        '{hcft_pkg::OP_BYTE,   8'hAA, 3'd1, 1'b0, hcft_pkg::ST_NONE},
        '{hcft_pkg::OP_BYTE,   8'hFF, 3'd2, 1'b0, hcft_pkg::ST_NONE},
        '{hcft_pkg::OP_BYTE,   8'h01, 3'd3, 1'b0, hcft_pkg::ST_NONE},
        '{hcft_pkg::OP_BYTE,   8'h02, 3'd4, 1'b0, hcft_pkg::ST_NONE},
        '{hcft_pkg::OP_BYTE,   8'h03, 3'd5, 1'b0, hcft_pkg::ST_NONE},
        '{hcft_pkg::OP_BYTE,   8'h05, 3'd6, 1'b0, hcft_pkg::ST_NONE},
        '{hcft_pkg::OP_END,    8'h00, 3'd7, 1'b1, hcft_pkg::ST_RANGE},
        '{OP_UNUSED_LAST,      8'hA5, 3'd2, 1'b0, hcft_pkg::ST_NONE},
        '{OP_UNUSED_FIRST,     8'h5A, 3'd5, 1'b0, hcft_pkg::ST_NONE}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    req_t        drive_req;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  frame_status;
    logic [7:0]  last_channel;
    logic [7:0]  wave_number;
    logic [15:0] channel_duration;
    logic [15:0] channel_count;
    logic [15:0] time_stamp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  limit_wdata;

    // Model of the block: frame buffer, channel tables, timers, register.
    logic [3:0]  model_limit;
    int          frame_pos;
    logic [7:0]  frame_buf [hcft_pkg::FRAME_LEN];
    logic [7:0]  seen_channel;
    logic [7:0]  wave_tab  [NUM_CH];
    logic [15:0] dur_tab   [NUM_CH];
    logic [15:0] count_tab [NUM_CH];
    logic [15:0] stamp_now;

    hcft_pkg::result_t pending_results [$];
    int          error_count = 0;
    int          requests_accepted = 0;
    int          results_checked = 0;
    int          limit_writes = 0;
    int          status_hits [6] = '{0, 0, 0, 0, 0, 0};

    int          idle_pct = 0;
    int          stall_pct = 0;
    logic        holding;
    event        hold_go;

    always #2 clk = ~clk;

    haptic_command_frame_and_timers #(
        .NUM_CHANNELS(NUM_CH)
    ) DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .opcode              (drive_req.op),
        .data_byte           (drive_req.data),
        .channel             (drive_req.ch),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .frame_status        (frame_status),
        .last_channel        (last_channel),
        .wave_number         (wave_number),
        .channel_duration    (channel_duration),
        .channel_count       (channel_count),
        .time_stamp          (time_stamp),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .valid_channel_limit (limit_wdata)
    );

    // Advance the model by one request and return the result it should produce.
    function automatic hcft_pkg::result_t apply_request(logic [2:0] op, logic [7:0] data,
                                                        logic [2:0] ch);
        hcft_pkg::result_t r;
        logic [7:0]        sum;
        int                idx;
        r.status = hcft_pkg::ST_NONE;
        if (op == hcft_pkg::OP_BYTE)
        begin
            // drop anything past the seventh byte until the next frame end
            if (frame_pos < hcft_pkg::FRAME_LEN)
            begin
                frame_buf[frame_pos] = data;
                frame_pos++;
            end
        end
        else if (op == hcft_pkg::OP_END)
        begin
            if (frame_pos < hcft_pkg::FRAME_LEN)
                r.status = hcft_pkg::ST_SHORT;
            else if (frame_buf[0] != hcft_pkg::HEAD0 || frame_buf[1] != hcft_pkg::HEAD1)
                r.status = hcft_pkg::ST_HEADER;
            else
            begin
                sum = frame_buf[2] + frame_buf[3] + frame_buf[4] + frame_buf[5];
                if (sum != frame_buf[6])
                    r.status = hcft_pkg::ST_SUM;
                else
                begin
                    seen_channel = frame_buf[2];
                    if (frame_buf[2] >= model_limit || frame_buf[2] >= NUM_CH)
                        r.status = hcft_pkg::ST_RANGE;
                    else
                    begin
                        idx = int'(frame_buf[2]);
                        wave_tab[idx]  = frame_buf[3];
                        dur_tab[idx]   = {frame_buf[4], frame_buf[5]};
                        count_tab[idx] = '0;
                        r.status = hcft_pkg::ST_OK;
                    end
                end
            end
            frame_pos = 0;
        end
        else if (op == hcft_pkg::OP_TICK)
        begin
            for (int i = 0; i < NUM_CH; i++)
                if (count_tab[i] != 0)
                    count_tab[i]--;
            stamp_now++;
        end
        else if (op == hcft_pkg::OP_RELOAD)
        begin
            count_tab[ch] = dur_tab[ch];
        end
        r.last_channel = seen_channel;
        r.wave         = wave_tab[ch];
        r.duration     = dur_tab[ch];
        r.count        = count_tab[ch];
        r.stamp        = stamp_now;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                      results_checked, name, got, want));
    endtask

    // Sample both channels and the register port at each edge, before any
    // of this edge's drives land.
    always @(posedge clk)
    begin
        hcft_pkg::result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                model_limit = limit_wdata;
                limit_writes++;
            end
            if (in_valid && !in_stall)
            begin
                want = apply_request(drive_req.op, drive_req.data, drive_req.ch);
                status_hits[want.status]++;
                // a typed-in status overrides the model's for that one field
                if (drive_req.pinned)
                    want.status = drive_req.pin_st;
                pending_results.push_back(want);
                requests_accepted++;
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with no request waiting");
                else
                begin
                    want = pending_results.pop_front();
                    check_field("frame_status", 16'(frame_status), 16'(want.status));
                    check_field("last_channel", 16'(last_channel), 16'(want.last_channel));
                    check_field("wave_number", 16'(wave_number), 16'(want.wave));
                    check_field("channel_duration", channel_duration, want.duration);
                    check_field("channel_count", channel_count, want.count);
                    check_field("time_stamp", time_stamp, want.stamp);
                end
                results_checked++;
            end
        end
    end

    // Receiver: random stall at the phase's rate, forced high during a hold.
    always @(posedge clk)
        out_stall <= holding || ($urandom_range(99) < stall_pct);

    // Long hold-off: keep the output stalled so the queue fills and the
    // block pushes back on its input while the sender keeps offering.
    initial
    begin
        holding = 1'b0;
        @(hold_go);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
    end

    // Offer one request, after a random idle gap, and hold it until taken.
    task automatic send_request(input req_t r);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        drive_req <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_plain(input logic [2:0] op, input logic [7:0] data,
                              input logic [2:0] ch);
        send_request(req_t'{op, data, ch, 1'b0, hcft_pkg::ST_NONE});
    endtask

    // Wait until every expected result has come back, then let the pipe settle.
    task automatic wait_results_drained();
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_channel_limit(input logic [3:0] value);
        cfg_valid   <= 1'b1;
        limit_wdata <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One random sequence: mostly whole frames with random content, some of
    // them broken on purpose, mixed with reloads, ticks, reads and noise.
    task automatic random_sequence(output int sent);
        int          kind;
        int          flaw;
        int          len;
        int          k;
        logic [7:0]  fb [hcft_pkg::FRAME_LEN];
        logic [15:0] dur;
        logic [2:0]  rch;
        sent = 0;
        kind = $urandom_range(99);
        rch  = 3'($urandom_range(7));
        if (kind < 50)
        begin
            fb[0] = hcft_pkg::HEAD0;
            fb[1] = hcft_pkg::HEAD1;
            fb[2] = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                             : 8'($urandom_range(NUM_CH - 1));
            fb[3] = 8'($urandom_range(255));
            // short durations so the counters run down to zero often
            dur   = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                             : 16'($urandom_range(12));
            fb[4] = dur[15:8];
            fb[5] = dur[7:0];
            fb[6] = fb[2] + fb[3] + fb[4] + fb[5];
            flaw  = $urandom_range(99);
            len   = hcft_pkg::FRAME_LEN;
            if (flaw < 8)
            begin
                k = $urandom_range(1);
                fb[k] = fb[k] ^ (8'd1 << $urandom_range(7));
            end
            else if (flaw < 16)
            begin
                k = $urandom_range(hcft_pkg::FRAME_LEN - 1, 2);
                fb[k] = fb[k] ^ (8'd1 << $urandom_range(7));
            end
            else if (flaw < 22)
                len = $urandom_range(hcft_pkg::FRAME_LEN - 1);
            else if (flaw < 27)
                len = hcft_pkg::FRAME_LEN + $urandom_range(3, 1);
            for (k = 0; k < len; k++)
            begin
                if (k < hcft_pkg::FRAME_LEN)
                    send_plain(hcft_pkg::OP_BYTE, fb[k], 3'($urandom_range(7)));
                else
                    send_plain(hcft_pkg::OP_BYTE, 8'($urandom_range(255)),
                               3'($urandom_range(7)));
            end
            send_plain(hcft_pkg::OP_END, 8'($urandom_range(255)), fb[2][2:0]);
            sent = len + 1;
            if ($urandom_range(1) == 1)
            begin
                send_plain(hcft_pkg::OP_RELOAD, 8'($urandom_range(255)), fb[2][2:0]);
                sent++;
            end
        end
        else if (kind < 62)
        begin
            send_plain(hcft_pkg::OP_RELOAD, 8'($urandom_range(255)), rch);
            sent = 1;
        end
        else if (kind < 80)
        begin
            len = $urandom_range(6, 1);
            for (k = 0; k < len; k++)
                send_plain(hcft_pkg::OP_TICK, 8'($urandom_range(255)),
                           3'($urandom_range(7)));
            sent = len;
        end
        else if (kind < 93)
        begin
            if ($urandom_range(2) == 0)
                send_plain(3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST)),
                           8'($urandom_range(255)), rch);
            else
                send_plain(hcft_pkg::OP_READ, 8'($urandom_range(255)), rch);
            sent = 1;
        end
        else
        begin
            // stray byte or a lone frame end
            if ($urandom_range(1) == 1)
                send_plain(hcft_pkg::OP_BYTE, 8'($urandom_range(255)), rch);
            else
                send_plain(hcft_pkg::OP_END, 8'($urandom_range(255)), rch);
            sent = 1;
        end
    endtask

    initial
    begin
        int ph;
        int phase_sent;
        int n;
        in_valid    = 1'b0;
        drive_req   = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        limit_wdata = '0;
        rst_n       = 1'b0;

        // Model reset state.
        model_limit  = hcft_pkg::LIMIT_RESET;
        frame_pos    = 0;
        seen_channel = '0;
        stamp_now    = '0;
        for (int i = 0; i < hcft_pkg::FRAME_LEN; i++)
            frame_buf[i] = '0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            wave_tab[i]  = '0;
            dur_tab[i]   = '0;
            count_tab[i] = '0;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, register at its reset value, no idling.
        for (n = 0; n < N_DIRECTED; n++)
            send_request(DIRECTED_ROWS[n]);
        in_valid <= 1'b0;
        wait_results_drained();

        // Random phases: no idling, idle sender, stalling receiver, both.
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_channel_limit(4'd8);
                1: write_channel_limit(4'd0);
                2: write_channel_limit(4'($urandom_range(7, 1)));
                default: write_channel_limit(hcft_pkg::LIMIT_RESET);
            endcase
            idle_pct  = (ph == 1) ? 76 : (ph == 3) ? 24 : 0;
            stall_pct <= (ph == 2) ? 76 : (ph == 3) ? 24 : 0;
            if (ph == 0)
                -> hold_go;
            phase_sent = 0;
            while (phase_sent < RANDOM_PER_PHASE)
            begin
                random_sequence(n);
                phase_sent += n;
            end
            in_valid <= 1'b0;
            wait_results_drained();
        end

        $display("covered %0d requests, %0d results compared, %0d limit writes",
                 requests_accepted, results_checked, limit_writes);
        $display("frame ends: accepted %0d, bad header %0d, bad checksum %0d",
                 status_hits[hcft_pkg::ST_OK], status_hits[hcft_pkg::ST_HEADER],
                 status_hits[hcft_pkg::ST_SUM]);
        $display("frame ends: range %0d, short %0d",
                 status_hits[hcft_pkg::ST_RANGE], status_hits[hcft_pkg::ST_SHORT]);
        if (error_count == 0)
            $display("haptic_command_frame_and_timers_tb: clean");
        else
            $display("haptic_command_frame_and_timers_tb: errors");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("timeout with %0d results still expected", pending_results.size());
        $display("haptic_command_frame_and_timers_tb: errors");
        $finish;
    end

endmodule
